>>> hw/rtl/ptbd_pkg.sv
// shared types and constants for the paper tape block deframer
package ptbd_pkg;

	// result kinds, carried on m_tuser
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_GOOD = 2'd1;
	localparam kind_t KIND_BAD  = 2'd2;
	localparam kind_t KIND_END  = 2'd3;

	localparam logic [7:0]  MARKER_BYTE = 8'd2;
	localparam logic [15:0] END_ADDRESS = 16'hFFFF;

	typedef logic [15:0] word_t;

	// result payload, declared highest field first, so word_address is the low field of m_tdata
	typedef struct packed {
		word_t computed_sum;
		word_t word_value;
		word_t word_address;
	} result_t;

	// 16-bit sum with end-around carry
	function automatic word_t add_end_around(input word_t sum, input word_t word);
		logic [16:0] s;
		s = {1'b0, sum} + {1'b0, word};
		return s[16] ? (s[15:0] + 16'd1) : s[15:0];
	endfunction

endpackage

>>> hw/rtl/paper_tape_block_deframer.sv
// paper tape block deframer: tape bytes in, data words and block status out
// a byte is held in the input register, and any result it gives then in the output register
// throughput: one byte per cycle; a byte waits in the input register only while a
// finished result still waits for m_tready
// reset: arst_n clears all parse state to the loader marker search and empties both
// registers; the output payload register is not reset
module paper_tape_block_deframer #(
	parameter int LOADER_BYTES = 123
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // tape_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // word_address, word_value, computed_sum
	output logic [1:0]  m_tuser    // kind
);

	// parse phases
	localparam logic [3:0] PH_SEEK    = 4'd0;
	localparam logic [3:0] PH_LOADER  = 4'd1;
	localparam logic [3:0] PH_LEN     = 4'd2;
	localparam logic [3:0] PH_ADDR_HI = 4'd3;
	localparam logic [3:0] PH_ADDR_LO = 4'd4;
	localparam logic [3:0] PH_DATA_HI = 4'd5;
	localparam logic [3:0] PH_DATA_LO = 4'd6;
	localparam logic [3:0] PH_SUM_HI  = 4'd7;
	localparam logic [3:0] PH_SUM_LO  = 4'd8;
	localparam logic [3:0] PH_DONE    = 4'd9;

	localparam logic [6:0] LOADER_LAST = 7'(LOADER_BYTES);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	logic [3:0]     phase_q;
	logic [6:0]     skip_count_q;
	logic [7:0]     words_left_q;
	ptbd_pkg::word_t block_address_q;
	logic [7:0]     word_offset_q;
	logic [7:0]     high_byte_q;
	ptbd_pkg::word_t running_sum_q;

	// output register
	logic              valid_s2;
	ptbd_pkg::kind_t   kind_s2;
	ptbd_pkg::result_t result_s2;

	// next-state and result logic
	logic [3:0]        phase_d;
	logic [6:0]        skip_count_d;
	logic [7:0]        words_left_d;
	ptbd_pkg::word_t   block_address_d;
	logic [7:0]        word_offset_d;
	logic [7:0]        high_byte_d;
	ptbd_pkg::word_t   running_sum_d;
	logic              emit;
	ptbd_pkg::kind_t   kind_d;
	ptbd_pkg::result_t result_d;
	ptbd_pkg::word_t   word;
	ptbd_pkg::word_t   sum_next;
	logic [6:0]        skip_next;
	logic [7:0]        left_next;

	logic out_free;
	logic fire_s1;

	// the output register can take a result when empty or draining this cycle
	assign out_free = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign word      = {high_byte_q, byte_s1};
	assign sum_next  = ptbd_pkg::add_end_around(running_sum_q, word);
	assign skip_next = skip_count_q + 7'd1;
	assign left_next = words_left_q - 8'd1;

	always_comb begin
		phase_d         = phase_q;
		skip_count_d    = skip_count_q;
		words_left_d    = words_left_q;
		block_address_d = block_address_q;
		word_offset_d   = word_offset_q;
		high_byte_d     = high_byte_q;
		running_sum_d   = running_sum_q;
		emit            = 1'b0;
		kind_d          = ptbd_pkg::KIND_DATA;
		result_d        = '0;
		unique case (phase_q)
			PH_SEEK: begin
				// everything before the loader marker is ignored
				if (byte_s1 == ptbd_pkg::MARKER_BYTE) begin
					skip_count_d = 7'd0;
					phase_d      = PH_LOADER;
				end
			end
			PH_LOADER: begin
				skip_count_d = skip_next;
				if (skip_next >= LOADER_LAST) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				// zero bytes between blocks are leader, skip them
				if (byte_s1 != 8'd0) begin
					words_left_d = byte_s1;
					phase_d      = PH_ADDR_HI;
				end
			end
			PH_ADDR_HI, PH_DATA_HI, PH_SUM_HI: begin
				high_byte_d = byte_s1;
				phase_d     = phase_q + 4'd1;
			end
			PH_ADDR_LO: begin
				if (word == ptbd_pkg::END_ADDRESS) begin
					// end of tape: report once, then ignore the rest
					phase_d               = PH_DONE;
					emit                  = 1'b1;
					kind_d                = ptbd_pkg::KIND_END;
					result_d.word_address = ptbd_pkg::END_ADDRESS;
				end else begin
					block_address_d = word;
					word_offset_d   = 8'd0;
					running_sum_d   = '0;
					phase_d         = PH_DATA_HI;
				end
			end
			PH_DATA_LO: begin
				running_sum_d         = sum_next;
				emit                  = 1'b1;
				kind_d                = ptbd_pkg::KIND_DATA;
				result_d.word_address = block_address_q + {8'd0, word_offset_q};
				result_d.word_value   = word;
				result_d.computed_sum = sum_next;
				word_offset_d         = word_offset_q + 8'd1;
				words_left_d          = left_next;
				phase_d               = (left_next == 8'd0) ? PH_SUM_HI : PH_DATA_HI;
			end
			PH_SUM_LO: begin
				emit                  = 1'b1;
				kind_d                = (word == running_sum_q) ? ptbd_pkg::KIND_GOOD
				                                                 : ptbd_pkg::KIND_BAD;
				result_d.word_address = block_address_q;
				result_d.word_value   = word;
				result_d.computed_sum = running_sum_q;
				phase_d               = PH_LEN;
			end
			default: begin
				// done or an unused code: bytes are dropped
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// parse state advances once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SEEK;
			skip_count_q    <= 7'd0;
			words_left_q    <= 8'd0;
			block_address_q <= '0;
			word_offset_q   <= 8'd0;
			high_byte_q     <= 8'd0;
			running_sum_q   <= '0;
		end else if (fire_s1) begin
			phase_q         <= phase_d;
			skip_count_q    <= skip_count_d;
			words_left_q    <= words_left_d;
			block_address_q <= block_address_d;
			word_offset_q   <= word_offset_d;
			high_byte_q     <= high_byte_d;
			running_sum_q   <= running_sum_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			kind_s2   <= kind_d;
			result_s2 <= result_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;
	assign m_tuser  = kind_s2;

endmodule

>>> hw/rtl/ptbd_checker.sv
// port-level checks for the paper tape block deframer, bound to the top level
module ptbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic m_xfer;
	assign m_xfer = m_tvalid && m_tready;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// the input side only stalls behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with the output free");

	// end of tape carries the end address and zero value and sum
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ptbd_pkg::KIND_END |->
		m_tdata == {32'd0, ptbd_pkg::END_ADDRESS})
		else $error("bad end of tape fields");

	// nothing follows end of tape
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && m_tuser == ptbd_pkg::KIND_END |=> !m_tvalid)
		else $error("result after end of tape");

	// block status agrees with the tape checksum and computed sum
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ptbd_pkg::KIND_GOOD || m_tuser == ptbd_pkg::KIND_BAD) |->
		((m_tdata[31:16] == m_tdata[47:32]) == (m_tuser == ptbd_pkg::KIND_GOOD)))
		else $error("block status disagrees with sums");

endmodule

bind paper_tape_block_deframer ptbd_checker u_ptbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
